// File: rtl/core/scfp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scfp_pkg: shared types and constants of the serial CAN frame parser
// Parser phases, framing constants and the decoded frame record.
// ---------------------------------------------------------------------------
package scfp_pkg;

    localparam logic [7:0] SyncByte   = 8'hF1;
    localparam int         IdBits     = 29;
    localparam int         ExtBit     = 31;
    localparam int         LenBits    = 4;
    localparam int         DataLanes  = 8;
    // id word (4) + length byte (1) + data lanes
    localparam int         FrameBytes = 5 + DataLanes;

    typedef enum logic [1:0] {
        PH_SYNC = 2'd0,
        PH_CMD  = 2'd1,
        PH_LEN  = 2'd2,
        PH_DATA = 2'd3
    } t_phase;

    typedef struct packed {
        logic [IdBits-1:0]      can_id;
        logic                   is_extended;
        logic [LenBits-1:0]     data_length;
        logic [8*DataLanes-1:0] data_bytes;
        logic [31:0]            frame_time;
    } t_frame;

endpackage

// File: rtl/core/scfp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scfp_rx_if / scfp_frame_if: valid/ready channels of the parser
// Serial byte channel in, decoded CAN frame channel out.
// ---------------------------------------------------------------------------
interface scfp_rx_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [31:0] time_us;

    modport source (output valid, output rx_byte, output time_us, input ready);
    modport sink   (input valid, input rx_byte, input time_us, output ready);
endinterface

interface scfp_frame_if;
    logic        valid;
    logic        ready;
    logic [28:0] can_id;
    logic        is_extended;
    logic [3:0]  data_length;
    logic [63:0] data_bytes;
    logic [31:0] frame_time;

    modport source (output valid, output can_id, output is_extended,
                    output data_length, output data_bytes, output frame_time,
                    input ready);
    modport sink   (input valid, input can_id, input is_extended,
                    input data_length, input data_bytes, input frame_time,
                    output ready);
endinterface

// File: rtl/core/scfp_frame_build.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scfp_frame_build: decode stored payload bytes into one CAN frame
// Little-endian id word, length nibble and zero-masked data lanes.
// ---------------------------------------------------------------------------
module scfp_frame_build (
    input  logic [7:0]      i_bytes [scfp_pkg::FrameBytes],
    input  logic [31:0]     i_time,
    output scfp_pkg::t_frame o_frame
);

    logic [31:0]                      id_word;
    logic [scfp_pkg::LenBits-1:0]     dlen;
    logic [8*scfp_pkg::DataLanes-1:0] data;

    always_comb begin
        id_word = {i_bytes[3], i_bytes[2], i_bytes[1], i_bytes[0]};
        dlen    = i_bytes[4][scfp_pkg::LenBits-1:0];
        data    = '0;
        // zero every lane at or beyond the length
        for (int i = 0; i < scfp_pkg::DataLanes; i++) begin
            if (scfp_pkg::LenBits'(i) < dlen) begin
                data[8*i +: 8] = i_bytes[5 + i];
            end
        end
        o_frame.can_id      = id_word[scfp_pkg::IdBits-1:0];
        o_frame.is_extended = id_word[scfp_pkg::ExtBit];
        o_frame.data_length = dlen;
        o_frame.data_bytes  = data;
        o_frame.frame_time  = i_time;
    end

endmodule

// File: rtl/core/serial_can_frame_parser.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serial_can_frame_parser: serial byte stream to CAN frame decoder
// Sync / command / length / payload parser with a byte store and frame out.
// ---------------------------------------------------------------------------
// Usage:
//   i_rx carries one serial byte per transfer with its microsecond time.
//   o_frame carries one decoded CAN frame per transfer; a frame is produced
//   when the last payload byte of a frame with command 0 arrives.
//   Path: a byte is held in the input register, then the parse step
//   updates the state and loads the result register, so a frame passes
//   the input register and then the result register before it is offered.
//   Throughput: one byte per cycle while the result register is free or
//   drains, set by the parse step (phase update, one store write, frame decode).
//   The result register parts the two sides: a byte is still taken while a
//   frame waits, until the input register is full and the parse step must
//   hold for the receiver. A stalled receiver only stalls the input once a
//   frame is held and another byte waits behind it.
//   Reset clears the phase to waiting for sync, the counters and all of
//   the payload store to zero, and empties both registers. Store bytes
//   that a short frame does not write keep their earlier values.
// ---------------------------------------------------------------------------
module serial_can_frame_parser #(
    parameter int STORE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    scfp_rx_if.sink             i_rx,
    scfp_frame_if.source        o_frame
);

    localparam int IdxW = $clog2(STORE_DEPTH);

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [31:0] r_in_time;

    // Parser state
    scfp_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_cmd, n_cmd;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_byte_index, n_byte_index;
    logic [7:0]       r_store [STORE_DEPTH];

    // Result register
    logic             r_out_valid;
    scfp_pkg::t_frame r_out;

    logic             advance;
    logic             step;
    logic             store_we;
    logic [8:0]       next_index;
    logic             frame_done;
    logic             emit;
    logic [7:0]       view [scfp_pkg::FrameBytes];
    scfp_pkg::t_frame built;

    // The parse step moves only when the result register is free or drains
    assign advance    = !r_out_valid || o_frame.ready;
    assign step       = r_in_valid && advance;
    assign i_rx.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
            r_in_time <= i_rx.time_us;
        end
    end

    // Store write: payload bytes past the end of the store are dropped
    assign store_we   = step && (r_phase == scfp_pkg::PH_DATA)
                        && ({1'b0, r_byte_index} < 9'(STORE_DEPTH));
    assign next_index = {1'b0, r_byte_index} + 9'd1;
    assign frame_done = (r_phase == scfp_pkg::PH_DATA)
                        && (next_index >= {1'b0, r_len});
    assign emit       = step && frame_done && (r_cmd == 8'd0);

    always_comb begin
        n_phase      = r_phase;
        n_cmd        = r_cmd;
        n_len        = r_len;
        n_byte_index = r_byte_index;
        if (step) begin
            unique case (r_phase)
                scfp_pkg::PH_SYNC: begin
                    if (r_in_byte == scfp_pkg::SyncByte) begin
                        n_phase = scfp_pkg::PH_CMD;
                    end
                end
                scfp_pkg::PH_CMD: begin
                    n_cmd   = r_in_byte;
                    n_phase = scfp_pkg::PH_LEN;
                end
                scfp_pkg::PH_LEN: begin
                    n_len        = r_in_byte;
                    n_byte_index = 8'd0;
                    n_phase      = scfp_pkg::PH_DATA;
                end
                scfp_pkg::PH_DATA: begin
                    // a length of zero still takes one byte
                    n_byte_index = next_index[7:0];
                    if (frame_done) begin
                        n_phase = scfp_pkg::PH_SYNC;
                    end
                end
                default: n_phase = scfp_pkg::PH_SYNC;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= scfp_pkg::PH_SYNC;
            r_cmd        <= 8'd0;
            r_len        <= 8'd0;
            r_byte_index <= 8'd0;
        end else begin
            r_phase      <= n_phase;
            r_cmd        <= n_cmd;
            r_len        <= n_len;
            r_byte_index <= n_byte_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STORE_DEPTH; k++) begin
                r_store[k] <= 8'd0;
            end
        end else if (store_we) begin
            r_store[r_byte_index[IdxW-1:0]] <= r_in_byte;
        end
    end

    // Decode sees the byte being written this cycle
    always_comb begin
        for (int k = 0; k < scfp_pkg::FrameBytes; k++) begin
            view[k] = (store_we && (r_byte_index == 8'(k))) ? r_in_byte : r_store[k];
        end
    end

    scfp_frame_build u_frame_build (
        .i_bytes (view),
        .i_time  (r_in_time),
        .o_frame (built)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= built;
        end
    end

    assign o_frame.valid       = r_out_valid;
    assign o_frame.can_id      = r_out.can_id;
    assign o_frame.is_extended = r_out.is_extended;
    assign o_frame.data_length = r_out.data_length;
    assign o_frame.data_bytes  = r_out.data_bytes;
    assign o_frame.frame_time  = r_out.frame_time;

endmodule
